/* src/nwr_pkg.sv */
// Shared constants, tables and types for the nearest waypoint reference window.
package nwr_pkg;

  localparam int MaxPoints  = 1024;
  localparam int IdxBits    = 10;
  localparam int CntBits    = 11;
  localparam int MaxAhead   = 64;
  localparam int AheadBits  = 7;
  localparam int StepBits   = 6;
  localparam int CoordBits  = 24;
  localparam int HeadBits   = 16;
  localparam int CordSteps  = 24;
  localparam int Prescale   = 24;
  // Width of the CORDIC vector datapath.
  localparam int CordBits   = CoordBits + 1 + Prescale + 3;
  localparam int IterBits   = 5;
  localparam int DiffBits   = CoordBits + 1;
  localparam int MagBits    = CoordBits;
  localparam int SqBits     = 2 * MagBits;
  localparam int DistBits   = SqBits + 1;

  localparam logic [1:0] RegPointCount  = 2'd0;
  localparam logic [1:0] RegPointsAhead = 2'd1;
  localparam logic       OpLoad         = 1'b0;
  localparam logic       OpQuery        = 1'b1;

  typedef struct packed {
    logic                        start;
    logic signed [DiffBits-1:0]  dx;
    logic signed [DiffBits-1:0]  dy;
  } cord_req_t;

  typedef struct packed {
    logic                        done;
    logic [HeadBits-1:0]         heading;
  } cord_rsp_t;

  function automatic logic [31:0] atan_entry(input logic [IterBits-1:0] i);
    logic [31:0] v;
    begin
      case (i)
        5'd0:  v = 32'd536870912;
        5'd1:  v = 32'd316933406;
        5'd2:  v = 32'd167458907;
        5'd3:  v = 32'd85004756;
        5'd4:  v = 32'd42667331;
        5'd5:  v = 32'd21354465;
        5'd6:  v = 32'd10679838;
        5'd7:  v = 32'd5340245;
        5'd8:  v = 32'd2670163;
        5'd9:  v = 32'd1335087;
        5'd10: v = 32'd667544;
        5'd11: v = 32'd333772;
        5'd12: v = 32'd166886;
        5'd13: v = 32'd83443;
        5'd14: v = 32'd41722;
        5'd15: v = 32'd20861;
        5'd16: v = 32'd10430;
        5'd17: v = 32'd5215;
        5'd18: v = 32'd2608;
        5'd19: v = 32'd1304;
        5'd20: v = 32'd652;
        5'd21: v = 32'd326;
        5'd22: v = 32'd163;
        5'd23: v = 32'd81;
        default: v = 32'd0;
      endcase
      return v;
    end
  endfunction

endpackage

/* src/nwr_cordic.sv */
// Iterative CORDIC vectoring unit: one micro-rotation per cycle, atan2 heading.
module nwr_cordic (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  nwr_pkg::cord_req_t  req_i,
  output nwr_pkg::cord_rsp_t  rsp_o
);

  typedef enum logic [1:0] {StIdle, StRun, StDone} state_e;

  state_e                                   state_q;
  logic signed [nwr_pkg::CordBits-1:0]      x_q, y_q;
  logic [31:0]                              z_q;
  logic [nwr_pkg::IterBits-1:0]             iter_q;
  logic [nwr_pkg::HeadBits-1:0]             head_q;

  logic signed [nwr_pkg::CordBits-1:0]      xs, ys, dx_ext, dy_ext;
  logic [31:0]                              z_nxt, z_rnd, ang;

  assign xs     = x_q >>> iter_q;
  assign ys     = y_q >>> iter_q;
  assign ang    = nwr_pkg::atan_entry(iter_q);
  assign z_nxt  = (y_q >= 0) ? z_q + ang : z_q - ang;
  assign z_rnd  = z_nxt + 32'h0000_8000;
  assign dx_ext = nwr_pkg::CordBits'(req_i.dx) <<< nwr_pkg::Prescale;
  assign dy_ext = nwr_pkg::CordBits'(req_i.dy) <<< nwr_pkg::Prescale;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      iter_q  <= '0;
      head_q  <= '0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (req_i.start) begin
            iter_q <= '0;
            if (req_i.dx == '0 && req_i.dy == '0) begin
              head_q  <= '0;
              state_q <= StDone;
            end else begin
              state_q <= StRun;
            end
          end
        end
        StRun: begin
          if (iter_q == nwr_pkg::IterBits'(nwr_pkg::CordSteps - 1)) begin
            state_q <= StDone;
            head_q  <= z_rnd[31:16];
          end
          iter_q <= iter_q + 1'b1;
        end
        StDone: state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && req_i.start) begin
      if (req_i.dx < 0) begin
        x_q <= -dx_ext;
        y_q <= -dy_ext;
        z_q <= 32'h8000_0000;
      end else begin
        x_q <= dx_ext;
        y_q <= dy_ext;
        z_q <= '0;
      end
    end else if (state_q == StRun) begin
      if (y_q >= 0) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
      end
      z_q <= z_nxt;
    end
  end

  assign rsp_o.done    = (state_q == StDone);
  assign rsp_o.heading = head_q;

endmodule

/* src/nwr_seq.sv */
// Sequencer: waypoint memory, nearest scan and window emission.
module nwr_seq (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic                                  opcode_i,
  input  logic [nwr_pkg::IdxBits-1:0]           point_index_i,
  input  logic signed [nwr_pkg::CoordBits-1:0]  coord_x_i,
  input  logic signed [nwr_pkg::CoordBits-1:0]  coord_y_i,
  input  logic [nwr_pkg::CntBits-1:0]           n_i,
  input  logic [nwr_pkg::AheadBits-1:0]         ahead_i,
  output logic                                  busy_o,
  output nwr_pkg::cord_req_t                    cord_req_o,
  input  nwr_pkg::cord_rsp_t                    cord_rsp_i,
  output logic                                  valid_o,
  output logic [nwr_pkg::IdxBits-1:0]           nearest_index_o,
  output logic signed [nwr_pkg::CoordBits-1:0]  ref_x_o,
  output logic signed [nwr_pkg::CoordBits-1:0]  ref_y_o,
  output logic signed [nwr_pkg::HeadBits-1:0]   ref_heading_o,
  output logic [nwr_pkg::StepBits-1:0]          step_number_o,
  output logic                                  last_point_o
);

  typedef enum logic [3:0] {
    StIdle, StScanRd, StScanSq, StScanCmp, StWinRd0, StWinRd1, StWinHold, StCord, StEmit
  } state_e;

  logic signed [nwr_pkg::CoordBits-1:0] mem_x [nwr_pkg::MaxPoints];
  logic signed [nwr_pkg::CoordBits-1:0] mem_y [nwr_pkg::MaxPoints];
  logic signed [nwr_pkg::CoordBits-1:0] rd_x_q, rd_y_q;
  logic [nwr_pkg::IdxBits-1:0]          rd_addr;

  state_e                               state_q;
  logic [nwr_pkg::CntBits-1:0]          scan_q;
  logic [nwr_pkg::IdxBits-1:0]          best_q, idx_q, nx_q;
  logic [nwr_pkg::DistBits-1:0]         best_d_q;
  logic                                 have_q;
  logic signed [nwr_pkg::CoordBits-1:0] qx_q, qy_q, x0_q, y0_q;
  logic [nwr_pkg::SqBits-1:0]           sx_q, sy_q;
  logic [nwr_pkg::StepBits-1:0]         step_q;
  logic [nwr_pkg::AheadBits-1:0]        ahead_q;
  logic [nwr_pkg::CntBits-1:0]          n_q;
  logic                                 start_cord_q;

  logic signed [nwr_pkg::DiffBits-1:0]  dxs, dys;
  logic [nwr_pkg::MagBits-1:0]          ax, ay;
  logic [nwr_pkg::DistBits-1:0]         sq_sum;
  logic [nwr_pkg::IdxBits-1:0]          idx_next;
  logic [nwr_pkg::CntBits-1:0]          idx_inc;

  assign dxs  = nwr_pkg::DiffBits'(rd_x_q) - nwr_pkg::DiffBits'(qx_q);
  assign dys  = nwr_pkg::DiffBits'(rd_y_q) - nwr_pkg::DiffBits'(qy_q);
  assign ax   = dxs[nwr_pkg::DiffBits-1] ? nwr_pkg::MagBits'(-dxs) : nwr_pkg::MagBits'(dxs);
  assign ay   = dys[nwr_pkg::DiffBits-1] ? nwr_pkg::MagBits'(-dys) : nwr_pkg::MagBits'(dys);
  assign sq_sum = nwr_pkg::DistBits'(sx_q) + nwr_pkg::DistBits'(sy_q);
  assign idx_inc  = nwr_pkg::CntBits'(idx_q) + 1'b1;
  assign idx_next = (idx_inc >= n_q) ? '0 : idx_inc[nwr_pkg::IdxBits-1:0];

  always_comb begin
    case (state_q)
      StWinRd0: rd_addr = (step_q == '0) ? best_q : idx_q;
      StWinRd1: rd_addr = nx_q;
      default:  rd_addr = scan_q[nwr_pkg::IdxBits-1:0];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o && opcode_i == nwr_pkg::OpLoad) begin
      mem_x[point_index_i] <= coord_x_i;
      mem_y[point_index_i] <= coord_y_i;
    end
    rd_x_q <= mem_x[rd_addr];
    rd_y_q <= mem_y[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      scan_q       <= '0;
      have_q       <= 1'b0;
      step_q       <= '0;
      valid_o      <= 1'b0;
      start_cord_q <= 1'b0;
    end else begin
      valid_o      <= 1'b0;
      start_cord_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (start_i && opcode_i == nwr_pkg::OpQuery) begin
            qx_q    <= coord_x_i;
            qy_q    <= coord_y_i;
            n_q     <= (n_i == '0) ? nwr_pkg::CntBits'(1)
                     : (n_i > nwr_pkg::CntBits'(nwr_pkg::MaxPoints))
                       ? nwr_pkg::CntBits'(nwr_pkg::MaxPoints) : n_i;
            ahead_q <= (ahead_i == '0) ? nwr_pkg::AheadBits'(1)
                     : (ahead_i > nwr_pkg::AheadBits'(nwr_pkg::MaxAhead))
                       ? nwr_pkg::AheadBits'(nwr_pkg::MaxAhead) : ahead_i;
            scan_q  <= '0;
            have_q  <= 1'b0;
            state_q <= StScanRd;
          end
        end
        StScanRd: state_q <= StScanSq;
        StScanSq: begin
          sx_q    <= ax * ax;
          sy_q    <= ay * ay;
          state_q <= StScanCmp;
        end
        StScanCmp: begin
          if (!have_q || sq_sum < best_d_q) begin
            have_q   <= 1'b1;
            best_d_q <= sq_sum;
            best_q   <= scan_q[nwr_pkg::IdxBits-1:0];
          end
          if (scan_q + 1'b1 >= n_q) begin
            state_q <= StWinRd0;
            step_q  <= '0;
          end else begin
            state_q <= StScanRd;
          end
          scan_q <= scan_q + 1'b1;
        end
        StWinRd0: begin
          if (step_q == '0) idx_q <= best_q;
          state_q <= StWinRd1;
        end
        StWinRd1: begin
          x0_q         <= rd_x_q;
          y0_q         <= rd_y_q;
          start_cord_q <= 1'b1;
          state_q      <= StWinHold;
        end
        StWinHold: begin
          state_q <= StCord;
        end
        StCord: begin
          if (cord_rsp_i.done) begin
            valid_o <= 1'b1;
            state_q <= StEmit;
          end
        end
        StEmit: begin
          idx_q  <= nx_q;
          step_q <= step_q + 1'b1;
          if (nwr_pkg::AheadBits'(step_q) + 1'b1 == ahead_q) state_q <= StIdle;
          else state_q <= StWinRd0;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // next index computed when idx_q settles (in StWinRd0 the new idx is not yet visible)
  always_ff @(posedge clk_i) begin
    if (state_q == StWinRd0 && step_q == '0) begin
      nx_q <= (nwr_pkg::CntBits'(best_q) + 1'b1 >= n_q) ? '0 : best_q + 1'b1;
    end else if (state_q == StWinRd0) begin
      nx_q <= idx_next;
    end
  end

  assign cord_req_o.start = start_cord_q;
  assign cord_req_o.dx    = nwr_pkg::DiffBits'(rd_x_q) - nwr_pkg::DiffBits'(x0_q);
  assign cord_req_o.dy    = nwr_pkg::DiffBits'(rd_y_q) - nwr_pkg::DiffBits'(y0_q);

  assign busy_o          = (state_q != StIdle);
  assign nearest_index_o = best_q;
  assign ref_x_o         = x0_q;
  assign ref_y_o         = y0_q;
  assign ref_heading_o   = cord_rsp_i.heading;
  assign step_number_o   = step_q;
  assign last_point_o    = (nwr_pkg::AheadBits'(step_q) + 1'b1 == ahead_q);

endmodule

/* src/nearest_waypoint_reference_window.sv */
// Top level of the nearest waypoint reference window.
// A load (opcode 0) writes one waypoint at the edge that accepts it; busy stays low.
// A query scans point_count waypoints through StScanRd, StScanSq and StScanCmp with
// a shared pair of squarers and one comparator, then emits points_ahead results with
// headings from the iterative 24-step CORDIC, skipped when a waypoint equals the next.
// busy stays high throughout; each result shows for one cycle under result_valid_o and
// cannot be held off, so the receiver must take every beat.
module nearest_waypoint_reference_window (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  opcode_i,
  input  logic [nwr_pkg::IdxBits-1:0]           point_index_i,
  input  logic signed [nwr_pkg::CoordBits-1:0]  coord_x_i,
  input  logic signed [nwr_pkg::CoordBits-1:0]  coord_y_i,
  input  logic                                  cfg_we_i,
  input  logic [1:0]                            cfg_idx_i,
  input  logic [nwr_pkg::CntBits-1:0]           cfg_data_i,
  output logic                                  result_valid_o,
  output logic [nwr_pkg::IdxBits-1:0]           nearest_index_o,
  output logic signed [nwr_pkg::CoordBits-1:0]  ref_x_o,
  output logic signed [nwr_pkg::CoordBits-1:0]  ref_y_o,
  output logic signed [nwr_pkg::HeadBits-1:0]   ref_heading_o,
  output logic [nwr_pkg::StepBits-1:0]          step_number_o,
  output logic                                  last_point_o
);

  logic [nwr_pkg::CntBits-1:0]   point_count_q;
  logic [nwr_pkg::AheadBits-1:0] points_ahead_q;
  nwr_pkg::cord_req_t            cord_req;
  nwr_pkg::cord_rsp_t            cord_rsp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q  <= nwr_pkg::CntBits'(1);
      points_ahead_q <= nwr_pkg::AheadBits'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        nwr_pkg::RegPointCount:  point_count_q  <= cfg_data_i;
        nwr_pkg::RegPointsAhead: points_ahead_q <= cfg_data_i[nwr_pkg::AheadBits-1:0];
        default: ;
      endcase
    end
  end

  nwr_seq u_seq (
    .clk_i, .rst_ni,
    .start_i(start), .opcode_i, .point_index_i, .coord_x_i, .coord_y_i,
    .n_i(point_count_q), .ahead_i(points_ahead_q),
    .busy_o(busy), .cord_req_o(cord_req), .cord_rsp_i(cord_rsp),
    .valid_o(result_valid_o), .nearest_index_o, .ref_x_o, .ref_y_o,
    .ref_heading_o, .step_number_o, .last_point_o
  );

  nwr_cordic u_cordic (.clk_i, .rst_ni, .req_i(cord_req), .rsp_o(cord_rsp));

  a_no_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy) else $error("result while idle");
  a_no_double: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("back-to-back results");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_point_o |=> !busy) else $error("busy after last point");

endmodule

/* dv/nwr_checker.sv */
// Scoreboard for the waypoint window block: predicts reference points and compares them.
`timescale 1ns / 1ps
module nwr_checker (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  input  logic                                  busy,
  input  logic                                  opcode_i,
  input  logic [nwr_pkg::IdxBits-1:0]           point_index_i,
  input  logic signed [nwr_pkg::CoordBits-1:0]  coord_x_i,
  input  logic signed [nwr_pkg::CoordBits-1:0]  coord_y_i,
  input  logic                                  cfg_we_i,
  input  logic [1:0]                            cfg_idx_i,
  input  logic [nwr_pkg::CntBits-1:0]           cfg_data_i,
  input  logic                                  result_valid_o,
  input  logic [nwr_pkg::IdxBits-1:0]           nearest_index_o,
  input  logic signed [nwr_pkg::CoordBits-1:0]  ref_x_o,
  input  logic signed [nwr_pkg::CoordBits-1:0]  ref_y_o,
  input  logic signed [nwr_pkg::HeadBits-1:0]   ref_heading_o,
  input  logic [nwr_pkg::StepBits-1:0]          step_number_o,
  input  logic                                  last_point_o,
  output int                                    pending_o,
  output int                                    errors_o
);

  typedef struct {
    logic [nwr_pkg::IdxBits-1:0]          idx;
    logic signed [nwr_pkg::CoordBits-1:0] x;
    logic signed [nwr_pkg::CoordBits-1:0] y;
    logic signed [nwr_pkg::HeadBits-1:0]  hd;
    logic [nwr_pkg::StepBits-1:0]         step;
    logic                                 last;
  } ref_point_t;

  localparam logic [31:0] AtanLut [nwr_pkg::CordSteps] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81};

  longint      wp_x [nwr_pkg::MaxPoints];
  longint      wp_y [nwr_pkg::MaxPoints];
  int unsigned path_len;
  int unsigned window_len;
  ref_point_t  window_q [$];

  function automatic logic [nwr_pkg::HeadBits-1:0] cordic_heading(longint dx, longint dy);
    longint      vx, vy, sx, sy;
    logic [31:0] z;
    if (dx == 0 && dy == 0) return '0;
    if (dx < 0) begin
      vx = -dx; vy = -dy; z = 32'h8000_0000;
    end else begin
      vx = dx; vy = dy; z = '0;
    end
    vx = vx * (64'sd1 << nwr_pkg::Prescale);
    vy = vy * (64'sd1 << nwr_pkg::Prescale);
    for (int i = 0; i < nwr_pkg::CordSteps; i++) begin
      sx = vx >>> i;
      sy = vy >>> i;
      if (vy >= 0) begin
        vx = vx + sy; vy = vy - sx; z = z + AtanLut[i];
      end else begin
        vx = vx - sy; vy = vy + sx; z = z - AtanLut[i];
      end
    end
    z = z + 32'h8000;
    return z[31:16];
  endfunction

  task automatic predict_window(longint qx, longint qy);
    int unsigned n, ahead, best, cur, nxt;
    longint      sq_sum, best_dist, ddx, ddy;
    ref_point_t  p;
    n = (path_len == 0) ? 1
      : (path_len > nwr_pkg::MaxPoints ? nwr_pkg::MaxPoints : path_len);
    ahead = (window_len == 0) ? 1
          : (window_len > nwr_pkg::MaxAhead ? nwr_pkg::MaxAhead : window_len);
    best = 0;
    best_dist = 0;
    for (int unsigned i = 0; i < n; i++) begin
      ddx = wp_x[i] - qx;
      ddy = wp_y[i] - qy;
      sq_sum = ddx * ddx + ddy * ddy;
      if (i == 0 || sq_sum < best_dist) begin
        best_dist = sq_sum; best = i;
      end
    end
    cur = best;
    for (int unsigned s = 0; s < ahead; s++) begin
      nxt = (cur + 1 >= n) ? 0 : cur + 1;
      p.idx  = best[nwr_pkg::IdxBits-1:0];
      p.x    = wp_x[cur][nwr_pkg::CoordBits-1:0];
      p.y    = wp_y[cur][nwr_pkg::CoordBits-1:0];
      p.hd   = cordic_heading(wp_x[nxt] - wp_x[cur], wp_y[nxt] - wp_y[cur]);
      p.step = s[nwr_pkg::StepBits-1:0];
      p.last = (s + 1 == ahead);
      window_q.insert(window_q.size(), p);
      cur = nxt;
    end
  endtask

  task automatic mismatch(string what, longint exp_v, longint act_v);
    $display("%0t mismatch %s: expected %0d actual %0d", $time, what, exp_v, act_v);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    ref_point_t e;
    if (!rst_ni) begin
      path_len   = 1;
      window_len = 1;
      window_q.delete();
      errors_o   = 0;
      pending_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == nwr_pkg::RegPointCount) path_len = cfg_data_i;
        else if (cfg_idx_i == nwr_pkg::RegPointsAhead)
          window_len = cfg_data_i[nwr_pkg::AheadBits-1:0];
      end
      if (result_valid_o) begin
        if (window_q.size() == 0) begin
          $display("%0t unexpected beat: nearest %0d x %0d y %0d", $time,
                   nearest_index_o, ref_x_o, ref_y_o);
          errors_o++;
        end else begin
          e = window_q.pop_front();
          if (nearest_index_o !== e.idx) mismatch("nearest_index", e.idx, nearest_index_o);
          if (ref_x_o !== e.x) mismatch("ref_x", e.x, ref_x_o);
          if (ref_y_o !== e.y) mismatch("ref_y", e.y, ref_y_o);
          if (ref_heading_o !== e.hd) mismatch("ref_heading", e.hd, ref_heading_o);
          if (step_number_o !== e.step) mismatch("step_number", e.step, step_number_o);
          if (last_point_o !== e.last) mismatch("last_point", e.last, last_point_o);
        end
      end
      if (start && !busy) begin
        if (opcode_i == nwr_pkg::OpLoad) begin
          wp_x[point_index_i] = coord_x_i;
          wp_y[point_index_i] = coord_y_i;
        end else begin
          predict_window(coord_x_i, coord_y_i);
        end
      end
      pending_o <= window_q.size();
    end
  end
endmodule

/* dv/tb_top.sv */
// Testbench top: drives loads, queries and register writes into the waypoint window block.
`timescale 1ns / 1ps
module tb_top;

  logic                                 clk_i = 1'b0;
  logic                                 rst_ni = 1'b0;
  logic                                 start = 1'b0;
  logic                                 busy;
  logic                                 opcode_i = nwr_pkg::OpLoad;
  logic [nwr_pkg::IdxBits-1:0]          point_index_i = '0;
  logic signed [nwr_pkg::CoordBits-1:0] coord_x_i = '0;
  logic signed [nwr_pkg::CoordBits-1:0] coord_y_i = '0;
  logic                                 cfg_we_i = 1'b0;
  logic [1:0]                           cfg_idx_i = nwr_pkg::RegPointCount;
  logic [nwr_pkg::CntBits-1:0]          cfg_data_i = '0;
  logic                                 result_valid_o;
  logic [nwr_pkg::IdxBits-1:0]          nearest_index_o;
  logic signed [nwr_pkg::CoordBits-1:0] ref_x_o, ref_y_o;
  logic signed [nwr_pkg::HeadBits-1:0]  ref_heading_o;
  logic [nwr_pkg::StepBits-1:0]         step_number_o;
  logic                                 last_point_o;
  int                                   pending, errors;

  bit          written [nwr_pkg::MaxPoints];
  bit          calm;
  int          sent;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  nearest_waypoint_reference_window dut (.*);

  nwr_checker checker_i (.*, .pending_o(pending), .errors_o(errors));

  initial begin
    #100_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic logic signed [nwr_pkg::CoordBits-1:0] rand_coord();
    case ($urandom_range(0, 3))
      0:       return nwr_pkg::CoordBits'($urandom);
      1:       return nwr_pkg::CoordBits'($signed($urandom_range(0, 8)) - 4);
      2:       return $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
      default: return nwr_pkg::CoordBits'($signed($urandom_range(0, 4000)) - 2000);
    endcase
  endfunction

  task automatic send(logic op, logic [nwr_pkg::IdxBits-1:0] idx,
                      logic signed [nwr_pkg::CoordBits-1:0] x,
                      logic signed [nwr_pkg::CoordBits-1:0] y);
    if (!calm && $urandom_range(0, 99) < 30) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start         <= 1'b1;
    opcode_i      <= op;
    point_index_i <= idx;
    coord_x_i     <= x;
    coord_y_i     <= y;
    do @(posedge clk_i); while (busy);
    if (op == nwr_pkg::OpLoad) written[idx] = 1'b1;
    sent++;
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || busy) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [nwr_pkg::CntBits-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // every slot a query can read must have been loaded
  task automatic setup_path(logic [nwr_pkg::CntBits-1:0] cnt,
                            logic [nwr_pkg::AheadBits-1:0] ahead);
    int unsigned n;
    n = (cnt == 0) ? 1 : (cnt > nwr_pkg::MaxPoints ? nwr_pkg::MaxPoints : cnt);
    for (int i = 0; i < n; i++)
      if (!written[i])
        send(nwr_pkg::OpLoad, nwr_pkg::IdxBits'(i), rand_coord(), rand_coord());
    settle();
    write_reg(nwr_pkg::RegPointCount, cnt);
    write_reg(nwr_pkg::RegPointsAhead, {4'(0), ahead});
  endtask

  initial begin
    int unsigned n, q;
    logic [nwr_pkg::CntBits-1:0] cnt;
    logic [nwr_pkg::AheadBits-1:0] ahead;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    calm = 1'b1;

    // reset config: one point, window of one, zero vector onto itself
    send(nwr_pkg::OpLoad, '0, 24'sh7fffff, 24'sh800000);
    send(nwr_pkg::OpQuery, '0, 24'sh800000, 24'sh7fffff);
    settle();
    // extremes, duplicate point, heading of pi, wrapping window
    send(nwr_pkg::OpLoad, nwr_pkg::IdxBits'(0), 24'sh800000, 24'sh800000);
    send(nwr_pkg::OpLoad, nwr_pkg::IdxBits'(1), 24'sh7fffff, 24'sh800000);
    send(nwr_pkg::OpLoad, nwr_pkg::IdxBits'(2), 24'sh7fffff, 24'sh800000);
    send(nwr_pkg::OpLoad, nwr_pkg::IdxBits'(3), -24'sd100, 24'sh800000);
    send(nwr_pkg::OpLoad, nwr_pkg::IdxBits'(4), 24'sh7fffff, 24'sh7fffff);
    send(nwr_pkg::OpLoad, nwr_pkg::IdxBits'(5), 24'sh800000, 24'sh7fffff);
    settle();
    write_reg(nwr_pkg::RegPointCount, nwr_pkg::CntBits'(4));
    write_reg(nwr_pkg::RegPointsAhead, nwr_pkg::CntBits'(9));
    write_reg(2'd2, '1);
    write_reg(2'd3, '1);
    send(nwr_pkg::OpQuery, '0, 24'sh7fffff, 24'sh7fffff);
    send(nwr_pkg::OpQuery, '0, 24'sh800000, 24'sh800000);
    send(nwr_pkg::OpQuery, '0, '0, 24'sh800000);
    settle();
    write_reg(nwr_pkg::RegPointCount, '0);
    write_reg(nwr_pkg::RegPointsAhead, '0);
    send(nwr_pkg::OpQuery, '0, 24'sh7fffff, '0);
    settle();
    write_reg(nwr_pkg::RegPointCount, nwr_pkg::CntBits'(6));
    write_reg(nwr_pkg::RegPointsAhead, nwr_pkg::CntBits'(127));
    send(nwr_pkg::OpQuery, '0, 24'sd5, -24'sd5);
    settle();

    while (sent < 280) begin
      calm = (sent > 120 && sent < 170);
      case ($urandom_range(0, 9))
        0:       cnt = nwr_pkg::CntBits'($urandom_range(0, 2));
        1:       cnt = nwr_pkg::CntBits'($urandom_range(17, 64));
        default: cnt = nwr_pkg::CntBits'($urandom_range(2, 16));
      endcase
      case ($urandom_range(0, 11))
        0:       ahead = '0;
        1:       ahead = nwr_pkg::AheadBits'(64);
        2:       ahead = nwr_pkg::AheadBits'($urandom_range(65, 127));
        default: ahead = nwr_pkg::AheadBits'($urandom_range(1, 10));
      endcase
      setup_path(cnt, ahead);
      n = (cnt == 0) ? 1 : cnt;
      q = $urandom_range(2, 6);
      for (int k = 0; k < q; k++) begin
        if ($urandom_range(0, 3) == 0)
          send(nwr_pkg::OpLoad, nwr_pkg::IdxBits'($urandom_range(0, n - 1)),
               rand_coord(), rand_coord());
        send(nwr_pkg::OpQuery, nwr_pkg::IdxBits'($urandom), rand_coord(), rand_coord());
      end
      settle();
    end

    for (int w = 0; w < 400000 && pending != 0; w++) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0 && pending == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

/* nearest_waypoint_reference_window.f */
src/nwr_pkg.sv
src/nwr_cordic.sv
src/nwr_seq.sv
src/nearest_waypoint_reference_window.sv
dv/nwr_checker.sv
dv/tb_top.sv
